// ===== sv/dfms_pkg.sv =====
// Shared types and constants for the dark-frame mean and deviation block.
package dfms_pkg;

  localparam int PIXELS_DEF = 16384;
  localparam int IDX_W      = 14;
  localparam int SMP_W      = 16;
  localparam int DSUM_W     = 33;
  localparam int SSUM_W     = 48;
  localparam int NF_W       = 16;
  localparam int AEXT_W     = 21;
  localparam int SQ_W       = 65;
  localparam int ROOT_W     = SSUM_W / 2;

  localparam logic OP_ACC = 1'b0;
  localparam logic OP_FIN = 1'b1;

  typedef struct packed {
    logic [SMP_W-1:0]  ref_val;
    logic [DSUM_W-1:0] dsum;
    logic [SSUM_W-1:0] ssum;
  } ent_t;

  typedef struct packed {
    logic [IDX_W-1:0]  pixel;
    logic [SMP_W-1:0]  ref_val;
    logic              neg;
    logic [SSUM_W-1:0] ssum;
  } fin_side_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel;
    logic [SMP_W-1:0] mean;
  } res_side_t;

endpackage

// ===== sv/dark_frame_mean_stddev.sv =====
// Top level: per-pixel dark-frame mean and standard deviation.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+----------------------------------
//  in_      | input     | in_valid/in_stall  | op, pixel_index, sample, first
//  out_     | output    | out_valid/out_stall| out_pixel, mean, std_dev
//  cfg      | APB write | psel/penable/pready| num_frames at address 0
//
// One word is taken per cycle while in_stall is low. An accumulate word reads
// the pixel entry from the state RAM and writes it back from the
// read-modify-write stage; a same-pixel word right behind it gets the new
// entry forwarded. A finalize word passes four staging registers, the
// 65-stage divider, one register, the 48-stage divider and the 24-stage root,
// then the output register. Reset clears the valid bits only, no RAM pass.
// A stalled result holds the whole pipeline and in_stall follows it.
module dark_frame_mean_stddev import dfms_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_pixel_index,
  input  logic [SMP_W-1:0]  in_sample,
  input  logic              in_first_frame,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_pixel,
  output logic [SMP_W-1:0]  out_mean,
  output logic [SMP_W-1:0]  out_std_dev,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AEXT_W-1:0] PIX_LIM = AEXT_W'(PIXELS);
  localparam int FSW = $bits(fin_side_t);
  localparam int RSW = $bits(res_side_t);

  // configuration
  logic [NF_W-1:0] num_frames_r;
  logic [NF_W-1:0] n_eff;
  logic [NF_W-1:0] n_m1;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-NF_W){1'b0}}, num_frames_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NF_W'(2);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      num_frames_r <= pwdata[NF_W-1:0];
    end
  end

  // treat 0 and 1 frames as 2
  assign n_eff = (num_frames_r < NF_W'(2)) ? NF_W'(2) : num_frames_r;
  assign n_m1  = n_eff - NF_W'(1);

  // global advance: hold everything while a result waits
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic              acc0;
  logic [AEXT_W-1:0] idx_ext0;
  logic [AW-1:0]     raddr;
  assign acc0     = in_valid && adv;
  assign idx_ext0 = {{(AEXT_W-IDX_W){1'b0}}, in_pixel_index};
  assign raddr    = idx_ext0[AW-1:0];

  // read-modify-write stage
  logic             v1_r, op1_r, first1_r, inr1_r, fwd1_r;
  logic [IDX_W-1:0] idx1_r;
  logic [SMP_W-1:0] smp1_r;
  logic [AW-1:0]    addr1_r;
  ent_t             fwdd1_r;
  ent_t             rdata;
  ent_t             ent;
  ent_t             wdata;
  logic             we;

  dfms_ram #(.W($bits(ent_t)), .D(PIXELS)) u_state (
    .clk   (clk),
    .we    (we),
    .waddr (addr1_r),
    .wdata (wdata),
    .re    (adv),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ent = fwd1_r ? fwdd1_r : rdata;

  logic [SMP_W:0]    d;
  logic [SMP_W-1:0]  ad_full;
  logic [2*SMP_W-1:0] dsq;
  logic [SMP_W:0]    dneg;
  assign d       = {1'b0, smp1_r} - {1'b0, ent.ref_val};
  assign dneg    = -d;
  assign ad_full = d[SMP_W] ? dneg[SMP_W-1:0] : d[SMP_W-1:0];
  assign dsq     = ad_full * ad_full;

  always_comb begin
    if (first1_r) begin
      wdata.ref_val = smp1_r;
      wdata.dsum    = '0;
      wdata.ssum    = '0;
    end else begin
      wdata.ref_val = ent.ref_val;
      wdata.dsum    = ent.dsum + {{(DSUM_W-SMP_W-1){d[SMP_W]}}, d};
      wdata.ssum    = ent.ssum + {{(SSUM_W-2*SMP_W){1'b0}}, dsq};
    end
  end

  assign we = v1_r && (op1_r == OP_ACC) && inr1_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      fwd1_r <= 1'b0;
    end else if (adv) begin
      v1_r   <= acc0;
      fwd1_r <= we && (addr1_r == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r    <= in_op;
      first1_r <= in_first_frame;
      inr1_r   <= (idx_ext0 < PIX_LIM);
      idx1_r   <= in_pixel_index;
      smp1_r   <= in_sample;
      addr1_r  <= raddr;
      fwdd1_r  <= wdata;
    end
  end

  // finalize: mask out-of-range pixels to a zero entry, take magnitude
  ent_t              fent;
  logic [DSUM_W-1:0] mag_c;
  assign fent  = inr1_r ? ent : '0;
  assign mag_c = fent.dsum[DSUM_W-1] ? (-fent.dsum) : fent.dsum;

  logic              vp0_r;
  fin_side_t         sp0_r;
  logic [DSUM_W-1:0] mag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp0_r <= 1'b0;
    end else if (adv) begin
      vp0_r <= v1_r && (op1_r == OP_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp0_r.pixel   <= idx1_r;
      sp0_r.ref_val <= fent.ref_val;
      sp0_r.neg     <= fent.dsum[DSUM_W-1];
      sp0_r.ssum    <= fent.ssum;
      mag0_r        <= mag_c;
    end
  end

  // square of the magnitude from three partial products
  logic              vp1_r, vp2_r;
  fin_side_t         sp1_r, sp2_r;
  logic [DSUM_W-1:0] mag1_r, mag2_r;
  logic [33:0]       phh_r;
  logic [32:0]       phl_r;
  logic [31:0]       pll_r;
  logic [SQ_W-1:0]   sq2_r;
  logic [SQ_W:0]     sq_sum;

  assign sq_sum = ({32'd0, phh_r} << 32) + ({33'd0, phl_r} << 17) + {34'd0, pll_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
    end else if (adv) begin
      vp1_r <= vp0_r;
      vp2_r <= vp1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp1_r  <= sp0_r;
      mag1_r <= mag0_r;
      phh_r  <= mag0_r[32:16] * mag0_r[32:16];
      phl_r  <= mag0_r[32:16] * mag0_r[15:0];
      pll_r  <= mag0_r[15:0] * mag0_r[15:0];
      sp2_r  <= sp1_r;
      mag2_r <= mag1_r;
      sq2_r  <= sq_sum[SQ_W-1:0];
    end
  end

  // trunc(sum^2/N) and trunc(|sum|/N) side by side
  logic            va;
  logic [SQ_W-1:0] qa, qb;
  logic [FSW-1:0]  sa_v;
  logic            vb_unused;
  logic [0:0]      sb_unused;
  fin_side_t       sa;

  dfms_div_pipe #(.DW(SQ_W), .VW(NF_W), .SW(FSW)) u_div_sq (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(vp2_r), .in_dividend(sq2_r), .in_divisor(n_eff), .in_side(sp2_r),
    .out_valid(va), .out_quot(qa), .out_side(sa_v)
  );

  dfms_div_pipe #(.DW(SQ_W), .VW(NF_W), .SW(1)) u_div_mean (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(vp2_r), .in_dividend({{(SQ_W-DSUM_W){1'b0}}, mag2_r}),
    .in_divisor(n_eff), .in_side(1'b0),
    .out_valid(vb_unused), .out_quot(qb), .out_side(sb_unused)
  );

  assign sa = fin_side_t'(sa_v);

  // mean with clamp, variance numerator floored at zero
  logic signed [DSUM_W+1:0] m_c;
  logic [SMP_W-1:0]         mean_c;
  logic [SSUM_W-1:0]        vnum_c;
  logic [SQ_W-1:0]          ss_ext;

  assign ss_ext = {{(SQ_W-SSUM_W){1'b0}}, sa.ssum};
  assign m_c = sa.neg ?
      ($signed({{(DSUM_W+2-SMP_W){1'b0}}, sa.ref_val}) - $signed({2'b00, qb[DSUM_W-1:0]})) :
      ($signed({{(DSUM_W+2-SMP_W){1'b0}}, sa.ref_val}) + $signed({2'b00, qb[DSUM_W-1:0]}));

  always_comb begin
    if (m_c[DSUM_W+1]) begin
      mean_c = '0;
    end else if (m_c > $signed((DSUM_W+2)'(65535))) begin
      mean_c = '1;
    end else begin
      mean_c = m_c[SMP_W-1:0];
    end
    if (ss_ext > qa) begin
      vnum_c = sa.ssum - qa[SSUM_W-1:0];
    end else begin
      vnum_c = '0;
    end
  end

  logic              ve_r;
  res_side_t         se_r;
  logic [SSUM_W-1:0] vnum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_r.pixel <= sa.pixel;
      se_r.mean  <= mean_c;
      vnum_r     <= vnum_c;
    end
  end

  // variance, then root
  logic              vc;
  logic [SSUM_W-1:0] var_q;
  logic [RSW-1:0]    sc_v;
  logic              vs;
  logic [ROOT_W-1:0] root;
  logic [RSW-1:0]    ss_v;
  res_side_t         sres;

  dfms_div_pipe #(.DW(SSUM_W), .VW(NF_W), .SW(RSW)) u_div_var (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(ve_r), .in_dividend(vnum_r), .in_divisor(n_m1), .in_side(se_r),
    .out_valid(vc), .out_quot(var_q), .out_side(sc_v)
  );

  dfms_sqrt_pipe #(.W(SSUM_W), .SW(RSW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(vc), .in_value(var_q), .in_side(sc_v),
    .out_valid(vs), .out_root(root), .out_side(ss_v)
  );

  assign sres = res_side_t'(ss_v);

  // output register
  logic [IDX_W-1:0] out_pixel_r;
  logic [SMP_W-1:0] out_mean_r, out_std_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= sres.pixel;
      out_mean_r  <= sres.mean;
      out_std_r   <= (root[ROOT_W-1:SMP_W] != '0) ? '1 : root[SMP_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_mean    = out_mean_r;
  assign out_std_dev = out_std_r;

endmodule

// ===== sv/dfms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfms_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dfms_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module dfms_div_pipe import dfms_pkg::*; #(
  parameter int DW = 65,
  parameter int VW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          v_r    [0:DW-1];
  logic [VW-1:0] rem_r  [0:DW-1];
  logic [DW-1:0] dq_r   [0:DW-1];
  logic [SW-1:0] side_r [0:DW-1];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          vp;
    logic [VW-1:0] rp;
    logic [DW-1:0] dp;
    logic [SW-1:0] sp;
    logic [VW:0]   t;
    logic [VW:0]   rn;
    logic          ge;

    if (k == 0) begin : g_first
      assign vp = in_valid;
      assign rp = '0;
      assign dp = in_dividend;
      assign sp = in_side;
    end else begin : g_next
      assign vp = v_r[k-1];
      assign rp = rem_r[k-1];
      assign dp = dq_r[k-1];
      assign sp = side_r[k-1];
    end

    assign t  = {rp, dp[DW-1]};
    assign ge = (t >= {1'b0, in_divisor});
    assign rn = ge ? (t - {1'b0, in_divisor}) : t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rn[VW-1:0];
        dq_r[k]   <= {dp[DW-2:0], ge};
        side_r[k] <= sp;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_quot  = dq_r[DW-1];
  assign out_side  = side_r[DW-1];

endmodule

// ===== sv/dfms_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, with side payload.
module dfms_sqrt_pipe import dfms_pkg::*; #(
  parameter int W  = SSUM_W,
  parameter int SW = 1,
  localparam int RW = W / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_value,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  logic          v_r    [0:RW-1];
  logic [RW+1:0] rem_r  [0:RW-1];
  logic [RW-1:0] root_r [0:RW-1];
  logic [W-1:0]  x_r    [0:RW-1];
  logic [SW-1:0] side_r [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          vp;
    logic [RW+1:0] rp;
    logic [RW-1:0] rootp;
    logic [W-1:0]  xp;
    logic [SW-1:0] sp;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic [RW+3:0] rn;
    logic          ge;

    if (k == 0) begin : g_first
      assign vp    = in_valid;
      assign rp    = '0;
      assign rootp = '0;
      assign xp    = in_value;
      assign sp    = in_side;
    end else begin : g_next
      assign vp    = v_r[k-1];
      assign rp    = rem_r[k-1];
      assign rootp = root_r[k-1];
      assign xp    = x_r[k-1];
      assign sp    = side_r[k-1];
    end

    assign t     = {rp, xp[W-1:W-2]};
    assign trial = {2'b00, rootp, 2'b01};
    assign ge    = (t >= trial);
    assign rn    = ge ? (t - trial) : t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rn[RW+1:0];
        root_r[k] <= {rootp[RW-2:0], ge};
        x_r[k]    <= {xp[W-3:0], 2'b00};
        side_r[k] <= sp;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// ===== sv/dfms_checker.sv =====
// Port-level checks for the dark-frame mean and deviation block, with bind.
module dfms_checker import dfms_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SMP_W-1:0] out_mean,
  input logic [SMP_W-1:0] out_std_dev
);

  // no result is shown right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input holds off only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back pressure");

  // a result waiting under stall keeps valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  // a stalled result word keeps its mean and deviation
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_stall) |=> ($stable(out_mean) && $stable(out_std_dev)))
    else $error("result payload changed under stall");

  // while the output is stalled the input side is stalled too on the next cycle
  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_stall) |=> (in_stall || !out_stall))
    else $error("input accepted while result still stalled");

endmodule

bind dark_frame_mean_stddev dfms_checker u_dfms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_mean    (out_mean),
  .out_std_dev (out_std_dev)
);

// ===== bench/testbench.sv =====
// Testbench for dark_frame_mean_stddev: directed table, then random words checked by a predictor.
module testbench import dfms_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_WORDS   = 1000;
  localparam int POOL_SIZE      = 8;

  typedef struct {
    logic [IDX_W-1:0] pixel;
    logic [SMP_W-1:0] mean;
    logic [SMP_W-1:0] std_dev;
  } pix_stat_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct {
    logic             op;
    logic [IDX_W-1:0] pixel;
    logic [SMP_W-1:0] sample;
    logic             first;
    bit               typed;
    logic [SMP_W-1:0] mean;
    logic [SMP_W-1:0] std_dev;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_ACC;
  logic [IDX_W-1:0]  in_pixel_index = '0;
  logic [SMP_W-1:0]  in_sample = '0;
  logic              in_first_frame = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_pixel;
  logic [SMP_W-1:0]  out_mean;
  logic [SMP_W-1:0]  out_std_dev;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor's own copy of the per-pixel state and the frame count.
  logic [SMP_W-1:0]  ref_mem [PIXELS_DEF];
  logic [DSUM_W-1:0] dsum_mem [PIXELS_DEF];
  logic [SSUM_W-1:0] ssum_mem [PIXELS_DEF];
  bit                ref_written [PIXELS_DEF];
  logic [NF_W-1:0]   frame_count = 16'd2;

  pix_stat_t         pending_stats[$];
  int                mismatches = 0;
  int                stats_seen = 0;
  int                words_sent = 0;
  int                idle_cycles = 0;
  bit                in_quiet = 1'b0;   // no sender gaps in this stretch
  bit                out_quiet = 1'b0;  // no receiver stalls in this stretch
  dir_row_t          dir_table[$];
  logic [IDX_W-1:0]  pool [POOL_SIZE];

  dark_frame_mean_stddev i_dut (.*);

  always #1 clk = ~clk;

  // Floor of the square root, bit by bit from the top.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Work out the mean and deviation a finalize word returns for this pixel.
  function automatic pix_stat_t finalize_stats(logic [IDX_W-1:0] pix);
    pix_stat_t       r;
    longint unsigned n, mag, q, rem, sq_div, ss, var_v, sd;
    longint          m;
    bit              neg;
    n = (frame_count < 2) ? 64'd2 : 64'(frame_count);
    neg = dsum_mem[pix][DSUM_W-1];
    mag = neg ? ((64'd1 << DSUM_W) - 64'(dsum_mem[pix])) : 64'(dsum_mem[pix]);
    q = mag / n;
    rem = mag % n;
    sq_div = q * mag + (rem * mag) / n;
    m = longint'(ref_mem[pix]) + (neg ? -longint'(q) : longint'(q));
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    ss = 64'(ssum_mem[pix]);
    var_v = (ss > sq_div) ? (ss - sq_div) / (n - 1) : 0;
    sd = floor_root(var_v);
    if (sd > 65535) sd = 65535;
    r.pixel = pix;
    r.mean = m[SMP_W-1:0];
    r.std_dev = sd[SMP_W-1:0];
    return r;
  endfunction

  // Update the state for an accumulate word.
  function automatic void accumulate(logic [IDX_W-1:0] pix, logic [SMP_W-1:0] smp, logic first);
    longint d;
    if (first) begin
      ref_mem[pix] = smp;
      dsum_mem[pix] = '0;
      ssum_mem[pix] = '0;
      ref_written[pix] = 1'b1;
    end else begin
      d = longint'(smp) - longint'(ref_mem[pix]);
      dsum_mem[pix] = dsum_mem[pix] + d[DSUM_W-1:0];
      ssum_mem[pix] = ssum_mem[pix] + SSUM_W'(d * d);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Drive one word, wait for it to be taken, then record what it should produce.
  task automatic send_word(logic op, logic [IDX_W-1:0] pix, logic [SMP_W-1:0] smp, logic first,
                           bit typed = 0, logic [SMP_W-1:0] tmean = '0,
                           logic [SMP_W-1:0] tsd = '0);
    pix_stat_t e;
    while (!in_quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel_index <= pix;
    in_sample <= smp;
    in_first_frame <= first;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (op == OP_FIN) begin
      e = finalize_stats(pix);
      if (typed) begin
        e.mean = tmean;
        e.std_dev = tsd;
      end
      pending_stats.push_back(e);
    end else begin
      accumulate(pix, smp, first);
    end
  endtask

  // Hold the sender until every pending result is in, then let the pipe drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [NF_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    frame_count = value;
    @(posedge clk);
  endtask

  // Random stretch: mostly well-formed runs on a small pool of pixels.
  task automatic random_phase(int count);
    int               k, pick, dice;
    logic [IDX_W-1:0] pix;
    logic [SMP_W-1:0] smp;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = IDX_W'($urandom);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(POOL_SIZE - 1);
      pix = pool[pick];
      dice = $urandom_range(99);
      if (!ref_written[pix] || dice < 8) begin
        send_word(OP_ACC, pix, SMP_W'($urandom), 1'b1);
      end else if (dice < 20) begin
        send_word(OP_FIN, pix, SMP_W'($urandom), 1'($urandom));
      end else if (dice < 25) begin
        // noise: a word to an arbitrary pixel; only finalized after a reference write
        send_word(OP_ACC, IDX_W'($urandom), SMP_W'($urandom), 1'b0);
      end else begin
        if ($urandom_range(1)) smp = SMP_W'($urandom);
        else smp = ref_mem[pix] + SMP_W'($urandom_range(64)) - SMP_W'(32);
        send_word(OP_ACC, pix, smp, 1'b0);
      end
    end
  endtask

  function automatic void add_row(logic op, int pix, int smp, logic first,
                                  bit typed = 0, int tmean = 0, int tsd = 0);
    dir_row_t r;
    r.op = op; r.pixel = IDX_W'(pix); r.sample = SMP_W'(smp); r.first = first;
    r.typed = typed; r.mean = SMP_W'(tmean); r.std_dev = SMP_W'(tsd);
    dir_table.push_back(r);
  endfunction

  // Receiver stalls at random except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !out_quiet && ($urandom_range(99) < 19);
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin
    pix_stat_t e;
    if (rst_n && out_valid && !out_stall) begin
      stats_seen++;
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected result, pixel", int'(out_pixel), -1);
      end else begin
        e = pending_stats.pop_front();
        if (out_pixel !== e.pixel)
          report_mismatch("out_pixel", int'(out_pixel), int'(e.pixel));
        if (out_mean !== e.mean)
          report_mismatch("mean", int'(out_mean), int'(e.mean));
        if (out_std_dev !== e.std_dev)
          report_mismatch("std_dev", int'(out_std_dev), int'(e.std_dev));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    foreach (ref_written[i]) begin
      ref_written[i] = 1'b0;
      ref_mem[i] = '0;
      dsum_mem[i] = '0;
      ssum_mem[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, frame count at its reset value of 2.
    add_row(OP_ACC, 0, 1234, 1);
    add_row(OP_FIN, 0, 65535, 1, 1, 1234, 0);           // fresh reference, junk fields ignored
    add_row(OP_ACC, 16383, 0, 1);
    repeat (3) add_row(OP_ACC, 16383, 65535, 0);
    add_row(OP_FIN, 16383, 0, 0, 1, 65535, 0);           // mean clamps high, variance negative
    add_row(OP_ACC, 1, 65535, 1);
    repeat (3) add_row(OP_ACC, 1, 0, 0);
    add_row(OP_FIN, 1, 0, 0, 1, 0, 0);                   // mean clamps low
    add_row(OP_ACC, 2, 32768, 1);
    repeat (5) begin
      add_row(OP_ACC, 2, 0, 0);
      add_row(OP_ACC, 2, 65535, 0);
    end
    add_row(OP_FIN, 2, 0, 0, 1, 32766, 65535);           // deviation clamps
    foreach (dir_table[i]) begin
      r = dir_table[i];
      send_word(r.op, r.pixel, r.sample, r.first, r.typed, r.mean, r.std_dev);
    end

    // Random phases, each under a different frame count; drain before every write.
    wait_drained();
    write_frame_count(16'd65535);
    random_phase(RANDOM_WORDS / 5);
    wait_drained();
    write_frame_count(16'd0);                            // treated as two
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    random_phase(RANDOM_WORDS / 5);
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    wait_drained();
    write_frame_count(16'd1);                            // treated as two
    random_phase(RANDOM_WORDS / 5);
    wait_drained();
    write_frame_count(16'($urandom_range(3, 20)));
    random_phase(RANDOM_WORDS / 5);
    wait_drained();
    write_frame_count(16'd2);
    random_phase(RANDOM_WORDS / 5);

    wait_drained();
    $display("summary: %0d words sent, %0d results checked under five frame counts",
             words_sent, stats_seen);
    $display("summary: clamps, negative variance and small frame counts covered");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_stats.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
